// ----- design/uvtw_pkg.sv -----
// Shared types, codes and helper functions for the UTF-8 tail-window validator.
package uvtw_pkg;

	localparam int unsigned MAX_BYTES_DEF      = 4096;
	localparam int unsigned MAX_CHARS_KEPT_DEF = 64;
	localparam int unsigned LIMIT_W            = 7;
	localparam int unsigned SCALAR_W           = 21;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;

	typedef enum logic [1:0] {
		ST_VALID     = 2'd0,
		ST_MALFORMED = 2'd1,
		ST_TOO_LONG  = 2'd2
	} status_t;

	// Minimum scalar class of the sequence in flight
	typedef enum logic [1:0] {
		CLS_NONE = 2'd0,
		CLS_2B   = 2'd1,
		CLS_3B   = 2'd2,
		CLS_4B   = 2'd3
	} cls_t;

	function automatic logic [SCALAR_W-1:0] class_min(input cls_t cls);
		logic [SCALAR_W-1:0] m;
		unique case (cls)
			CLS_2B:   m = 21'h00080;
			CLS_3B:   m = 21'h00800;
			CLS_4B:   m = 21'h10000;
			default:  m = 21'h00000;
		endcase
		return m;
	endfunction

	function automatic int unsigned addr_bits(input int unsigned depth);
		return (depth > 1) ? $clog2(depth) : 1;
	endfunction

endpackage

// ----- design/uvtw_ram.sv -----
// Simple dual-port RAM: one write port, one registered read port with enable.
module uvtw_ram #(
	parameter int unsigned WIDTH = 12,
	parameter int unsigned DEPTH = 64,
	localparam int unsigned AW   = uvtw_pkg::addr_bits(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// hold read data until the next enabled read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- design/utf8_validate_tail_window_top.sv -----
// Top level: strict UTF-8 checker that reports the start of the last N characters.
// A text-ending word passes from the input register into the result register, which shows it.
// Throughput: one word per cycle; only a result that is stalled on the output blocks input.
// Byte checking, counting and the start-offset ring write all happen in one stage.
// Reset (arst_n low, asynchronous): text state cleared, char_limit = 64, pipeline empty.
// The start-offset ring is not cleared; only entries written in the current text are read.
module utf8_validate_tail_window_top #(
	parameter int unsigned MAX_BYTES      = uvtw_pkg::MAX_BYTES_DEF,
	parameter int unsigned MAX_CHARS_KEPT = uvtw_pkg::MAX_CHARS_KEPT_DEF,
	localparam int unsigned POS_W         = $clog2(MAX_BYTES + 1),
	localparam int unsigned KEPT_W        = $clog2(MAX_CHARS_KEPT + 1)
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// configuration
	input  logic                            cfg_we,
	input  logic [uvtw_pkg::LIMIT_W-1:0]    cfg_wdata,
	// input word channel
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [7:0]                      data_byte,
	input  logic                            is_last,
	input  logic                            is_empty,
	// result word channel
	output logic                            out_valid,
	input  logic                            out_stall,
	output uvtw_pkg::status_t               status,
	output logic [POS_W-1:0]                keep_from,
	output logic [POS_W-1:0]                total_bytes,
	output logic [KEPT_W-1:0]               chars_kept
);

	localparam int unsigned IDX_W   = uvtw_pkg::addr_bits(MAX_CHARS_KEPT);
	localparam int unsigned RING_W  = $clog2(MAX_BYTES);
	localparam int unsigned LIM_CW  = (KEPT_W > uvtw_pkg::LIMIT_W) ? KEPT_W : uvtw_pkg::LIMIT_W;
	localparam int unsigned CNT_CW  = (POS_W > KEPT_W) ? POS_W : KEPT_W;
	localparam int unsigned DIFF_W  = KEPT_W + 1;
	localparam int unsigned SW      = uvtw_pkg::SCALAR_W;

	// ------------------------------------------------------------------
	// Configuration register
	// ------------------------------------------------------------------
	logic [uvtw_pkg::LIMIT_W-1:0] char_limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char_limit_q <= uvtw_pkg::LIMIT_RESET;
		end else if (cfg_we) begin
			char_limit_q <= cfg_wdata;
		end
	end

	// Saturate the limit at the ring depth
	logic [KEPT_W-1:0] limit;
	always_comb begin
		if (LIM_CW'(char_limit_q) > LIM_CW'(MAX_CHARS_KEPT)) begin
			limit = KEPT_W'(MAX_CHARS_KEPT);
		end else begin
			limit = KEPT_W'(char_limit_q);
		end
	end

	// ------------------------------------------------------------------
	// Stage 1: input register
	// ------------------------------------------------------------------
	logic       valid_s1;
	logic [7:0] data_byte_s1;
	logic       is_last_s1;
	logic       is_empty_s1;

	logic valid_s2;
	logic s2_free;
	logic ends_s1;
	logic go_s1;
	logic in_acc;

	// A word that ends a text needs the result slot; all others move on freely.
	assign s2_free  = !valid_s2 || !out_stall;
	assign ends_s1  = is_last_s1 || is_empty_s1;
	assign go_s1    = valid_s1 && (!ends_s1 || s2_free);
	assign in_stall = valid_s1 && !go_s1;
	assign in_acc   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (go_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			data_byte_s1 <= data_byte;
			is_last_s1   <= is_last;
			is_empty_s1  <= is_empty;
		end
	end

	// ------------------------------------------------------------------
	// Text state
	// ------------------------------------------------------------------
	logic [1:0]        pend_q,  pend_n;
	logic [SW-1:0]     acc_q,   acc_n;
	uvtw_pkg::cls_t    cls_q,   cls_n;
	uvtw_pkg::status_t err_q,   err_n;
	logic [POS_W-1:0]  pos_q,   pos_n;
	logic [POS_W-1:0]  cnt_q,   cnt_n;
	logic [IDX_W-1:0]  wptr_q,  wptr_n;
	logic              ring_wr;

	// Check one byte against strict UTF-8 and advance the counters.
	always_comb begin
		pend_n  = pend_q;
		acc_n   = acc_q;
		cls_n   = cls_q;
		err_n   = err_q;
		pos_n   = pos_q;
		cnt_n   = cnt_q;
		wptr_n  = wptr_q;
		ring_wr = 1'b0;
		if (!is_empty_s1) begin
			if (err_q != uvtw_pkg::ST_VALID) begin
				// error seen: only count the byte, saturating
				if (pos_q < POS_W'(MAX_BYTES)) begin
					pos_n = pos_q + POS_W'(1);
				end
			end else if (pos_q >= POS_W'(MAX_BYTES)) begin
				err_n = uvtw_pkg::ST_TOO_LONG;
			end else begin
				pos_n = pos_q + POS_W'(1);
				if (pend_q == 2'd0) begin
					// new character: record its start offset
					ring_wr = 1'b1;
					cnt_n   = cnt_q + POS_W'(1);
					if (wptr_q == IDX_W'(MAX_CHARS_KEPT - 1)) begin
						wptr_n = '0;
					end else begin
						wptr_n = wptr_q + IDX_W'(1);
					end
					priority if (data_byte_s1 <= 8'h7f) begin
						acc_n = SW'(data_byte_s1);
						cls_n = uvtw_pkg::CLS_NONE;
					end else if (data_byte_s1 >= 8'hc2 && data_byte_s1 <= 8'hdf) begin
						acc_n  = SW'(data_byte_s1[4:0]);
						cls_n  = uvtw_pkg::CLS_2B;
						pend_n = 2'd1;
					end else if (data_byte_s1 >= 8'he0 && data_byte_s1 <= 8'hef) begin
						acc_n  = SW'(data_byte_s1[3:0]);
						cls_n  = uvtw_pkg::CLS_3B;
						pend_n = 2'd2;
					end else if (data_byte_s1 >= 8'hf0 && data_byte_s1 <= 8'hf4) begin
						acc_n  = SW'(data_byte_s1[2:0]);
						cls_n  = uvtw_pkg::CLS_4B;
						pend_n = 2'd3;
					end else begin
						err_n = uvtw_pkg::ST_MALFORMED;
					end
				end else begin
					if (data_byte_s1[7:6] != 2'b10) begin
						err_n = uvtw_pkg::ST_MALFORMED;
					end else begin
						acc_n  = {acc_q[SW-7:0], data_byte_s1[5:0]};
						pend_n = pend_q - 2'd1;
						// sequence complete: reject overlong, surrogate, out of range
						if (pend_q == 2'd1) begin
							if (acc_n < uvtw_pkg::class_min(cls_q) ||
							    (acc_n >= 21'h00d800 && acc_n <= 21'h00dfff) ||
							    acc_n > 21'h10ffff) begin
								err_n = uvtw_pkg::ST_MALFORMED;
							end
						end
					end
				end
			end
		end
	end

	// Advance text state; a text-ending word clears it for the next text.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
			acc_q  <= '0;
			cls_q  <= uvtw_pkg::CLS_NONE;
			err_q  <= uvtw_pkg::ST_VALID;
			pos_q  <= '0;
			cnt_q  <= '0;
			wptr_q <= '0;
		end else if (go_s1) begin
			if (ends_s1) begin
				pend_q <= '0;
				acc_q  <= '0;
				cls_q  <= uvtw_pkg::CLS_NONE;
				err_q  <= uvtw_pkg::ST_VALID;
				pos_q  <= '0;
				cnt_q  <= '0;
				wptr_q <= '0;
			end else begin
				pend_q <= pend_n;
				acc_q  <= acc_n;
				cls_q  <= cls_n;
				err_q  <= err_n;
				pos_q  <= pos_n;
				cnt_q  <= cnt_n;
				wptr_q <= wptr_n;
			end
		end
	end

	// ------------------------------------------------------------------
	// End-of-text result
	// ------------------------------------------------------------------
	uvtw_pkg::status_t  fin_status;
	logic [KEPT_W-1:0]  fin_kept;
	logic [POS_W-1:0]   fin_keep;
	logic               fin_ring;
	logic [DIFF_W-1:0]  diff;
	logic [IDX_W-1:0]   raddr;
	logic               ram_we;
	logic               ram_re;
	logic [RING_W-1:0]  ram_wdata;
	logic [RING_W-1:0]  ram_rdata;

	assign ram_we    = go_s1 && ring_wr;
	assign ram_re    = go_s1 && ends_s1;
	assign ram_wdata = RING_W'(pos_q);

	// Ring slot of the first kept character: (write pointer - limit) mod depth
	always_comb begin
		diff = DIFF_W'(wptr_n) - DIFF_W'(limit);
		if (diff[DIFF_W-1]) begin
			diff = diff + DIFF_W'(MAX_CHARS_KEPT);
		end
		raddr = IDX_W'(diff);
	end

	always_comb begin
		fin_status = err_n;
		if (err_n == uvtw_pkg::ST_VALID && pend_n != 2'd0) begin
			// sequence cut off at the end of the text
			fin_status = uvtw_pkg::ST_MALFORMED;
		end
		fin_kept = '0;
		fin_keep = '0;
		fin_ring = 1'b0;
		if (fin_status == uvtw_pkg::ST_VALID) begin
			priority if (limit == '0) begin
				fin_keep = pos_n;
			end else if (CNT_CW'(cnt_n) > CNT_CW'(limit)) begin
				fin_kept = limit;
				if (ram_we && raddr == wptr_q) begin
					// slot is being written by this very byte: forward it
					fin_keep = pos_q;
				end else begin
					fin_ring = 1'b1;
				end
			end else begin
				fin_kept = KEPT_W'(cnt_n);
			end
		end
	end

	uvtw_ram #(
		.WIDTH (RING_W),
		.DEPTH (MAX_CHARS_KEPT)
	) u_ring (
		.clk   (clk),
		.we    (ram_we),
		.waddr (wptr_q),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (raddr),
		.rdata (ram_rdata)
	);

	// ------------------------------------------------------------------
	// Stage 2: result register
	// ------------------------------------------------------------------
	uvtw_pkg::status_t status_s2;
	logic [POS_W-1:0]  keep_s2;
	logic [POS_W-1:0]  total_s2;
	logic [KEPT_W-1:0] kept_s2;
	logic              ring_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ram_re) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	// hold the result while the output is stalled
	always_ff @(posedge clk) begin
		if (ram_re) begin
			status_s2 <= fin_status;
			keep_s2   <= fin_keep;
			total_s2  <= pos_n;
			kept_s2   <= fin_kept;
			ring_s2   <= fin_ring;
		end
	end

	assign out_valid   = valid_s2;
	assign status      = status_s2;
	assign keep_from   = ring_s2 ? POS_W'(ram_rdata) : keep_s2;
	assign total_bytes = total_s2;
	assign chars_kept  = kept_s2;

endmodule

// ----- design/uvtw_checker.sv -----
// Port-level assertions for the UTF-8 tail-window validator, bound to its top level.
module uvtw_checker #(
	parameter int unsigned MAX_BYTES      = uvtw_pkg::MAX_BYTES_DEF,
	parameter int unsigned MAX_CHARS_KEPT = uvtw_pkg::MAX_CHARS_KEPT_DEF,
	localparam int unsigned POS_W         = $clog2(MAX_BYTES + 1),
	localparam int unsigned KEPT_W        = $clog2(MAX_CHARS_KEPT + 1)
) (
	input logic              clk,
	input logic              arst_n,
	input logic              out_valid,
	input logic              out_stall,
	input logic [1:0]        status,
	input logic [POS_W-1:0]  keep_from,
	input logic [POS_W-1:0]  total_bytes,
	input logic [KEPT_W-1:0] chars_kept
);

	// a stalled result stays and holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) &&
		$stable(keep_from) && $stable(total_bytes) && $stable(chars_kept))
		else $error("stalled result word changed");

	// a failed text carries no window
	a_bad_no_window: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != uvtw_pkg::ST_VALID |-> keep_from == '0 && chars_kept == '0)
		else $error("window reported on a failed text");

	// the window starts inside the text
	a_keep_in_text: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> keep_from <= total_bytes && total_bytes <= POS_W'(MAX_BYTES))
		else $error("keep_from or total_bytes out of range");

	// kept characters never exceed the ring nor the bytes behind keep_from
	a_kept_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> chars_kept <= KEPT_W'(MAX_CHARS_KEPT) &&
		POS_W'(chars_kept) <= total_bytes - keep_from)
		else $error("chars_kept out of range");

endmodule

bind utf8_validate_tail_window_top uvtw_checker #(
	.MAX_BYTES      (MAX_BYTES),
	.MAX_CHARS_KEPT (MAX_CHARS_KEPT)
) u_uvtw_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.status      (status),
	.keep_from   (keep_from),
	.total_bytes (total_bytes),
	.chars_kept  (chars_kept)
);

// ----- bench/tb_top.sv -----
`timescale 1ns / 100ps
// Self-checking bench for the UTF-8 tail-window validator: directed and random texts.
module tb_top;

	localparam int unsigned TEXT_MAX     = uvtw_pkg::MAX_BYTES_DEF;
	localparam int unsigned RING_SIZE    = uvtw_pkg::MAX_CHARS_KEPT_DEF;
	// the last text of a chunk overshoots the budget; nine chunks run in all
	localparam int unsigned CHUNK_WORDS  = 110;
	localparam int unsigned LONG_HOLD    = 150;
	localparam int unsigned RUN_LIMIT_NS = 4_000_000;

	// One input word as it goes on the wire
	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       empty;
	} word_t;

	// What the block should report when a text ends
	typedef struct packed {
		uvtw_pkg::status_t status;
		logic [12:0]       keep_from;
		logic [12:0]       total;
		logic [6:0]        kept;
	} summary_t;

	logic                         clk       = 1'b0;
	logic                         arst_n    = 1'b0;
	logic                         cfg_we    = 1'b0;
	logic [uvtw_pkg::LIMIT_W-1:0] cfg_wdata = '0;
	logic                         in_valid  = 1'b0;
	logic                         in_stall;
	logic [7:0]                   data_byte = '0;
	logic                         is_last   = 1'b0;
	logic                         is_empty  = 1'b0;
	logic                         out_valid;
	logic                         out_stall = 1'b0;
	uvtw_pkg::status_t            status;
	logic [12:0]                  keep_from;
	logic [12:0]                  total_bytes;
	logic [6:0]                   chars_kept;

	utf8_validate_tail_window_top uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.data_byte   (data_byte),
		.is_last     (is_last),
		.is_empty    (is_empty),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.keep_from   (keep_from),
		.total_bytes (total_bytes),
		.chars_kept  (chars_kept)
	);

	// Words waiting for the driver, summaries waiting for the block
	word_t       words_out[$];
	summary_t    summaries_due[$];
	logic [7:0]  text_buf[$];      // scratch bytes of the text being built
	int unsigned words_queued   = 0;
	int unsigned words_accepted = 0;
	int unsigned texts_queued   = 0;
	int unsigned fails          = 0;
	logic        word_taken     = 1'b0;

	// Rates and the long receiver hold-off
	int unsigned tx_idle_pct    = 0;
	int unsigned rx_idle_pct    = 0;
	logic        long_hold_req  = 1'b0;
	logic        long_hold_done = 1'b0;
	int unsigned hold_left      = 0;

	// Checker state: one text in flight plus the limit register
	logic [1:0]        cont_left   = '0;
	logic [20:0]       scalar      = '0;
	uvtw_pkg::cls_t    seq_class   = uvtw_pkg::CLS_NONE;
	uvtw_pkg::status_t text_status = uvtw_pkg::ST_VALID;
	logic [12:0]       byte_count  = '0;
	logic [12:0]       char_total  = '0;
	logic [11:0]       start_offs [RING_SIZE];
	logic [6:0]        limit_reg   = uvtw_pkg::LIMIT_RESET;

	initial forever #6 clk = ~clk;

	// Give up well past the slowest correct run
	initial begin
		#(RUN_LIMIT_NS);
		$display("Test completed with failures");
		$finish;
	end

	// Advance the checker by one byte of the current text
	task automatic take_byte(input logic [7:0] b);
		logic below_min;
		if (text_status != uvtw_pkg::ST_VALID) begin
			// after an error only the length moves, and it saturates
			if (byte_count < TEXT_MAX) byte_count++;
			return;
		end
		if (byte_count >= TEXT_MAX) begin
			text_status = uvtw_pkg::ST_TOO_LONG;
			return;
		end
		if (cont_left == 0) begin
			// a lead byte opens a character: log where it starts
			start_offs[char_total % RING_SIZE] = byte_count[11:0];
			char_total++;
			if (b <= 8'h7f) begin
				scalar    = {13'b0, b};
				seq_class = uvtw_pkg::CLS_NONE;
			end else if (b >= 8'hc2 && b <= 8'hdf) begin
				scalar    = {16'b0, b[4:0]};
				seq_class = uvtw_pkg::CLS_2B;
				cont_left = 2'd1;
			end else if (b >= 8'he0 && b <= 8'hef) begin
				scalar    = {17'b0, b[3:0]};
				seq_class = uvtw_pkg::CLS_3B;
				cont_left = 2'd2;
			end else if (b >= 8'hf0 && b <= 8'hf4) begin
				scalar    = {18'b0, b[2:0]};
				seq_class = uvtw_pkg::CLS_4B;
				cont_left = 2'd3;
			end else begin
				text_status = uvtw_pkg::ST_MALFORMED;
			end
		end else if (b[7:6] != 2'b10) begin
			text_status = uvtw_pkg::ST_MALFORMED;
		end else begin
			scalar = {scalar[14:0], b[5:0]};
			cont_left--;
			if (cont_left == 0) begin
				// overlong, surrogate or past the last code point
				case (seq_class)
					uvtw_pkg::CLS_2B: below_min = scalar < 21'h80;
					uvtw_pkg::CLS_3B: below_min = scalar < 21'h800;
					uvtw_pkg::CLS_4B: below_min = scalar < 21'h10000;
					default:          below_min = 1'b0;
				endcase
				if (below_min || (scalar >= 21'hd800 && scalar <= 21'hdfff) ||
						scalar > 21'h10ffff)
					text_status = uvtw_pkg::ST_MALFORMED;
			end
		end
		byte_count++;
	endtask

	// Apply one accepted word; on the end of a text, log its summary
	task automatic accept_word(input word_t w);
		summary_t   s;
		logic [6:0] lim;
		if (!w.empty) take_byte(w.data);
		if (!w.last && !w.empty) return;
		// a sequence left open at the end is malformed
		if (text_status == uvtw_pkg::ST_VALID && cont_left != 0)
			text_status = uvtw_pkg::ST_MALFORMED;
		s.status    = text_status;
		s.keep_from = '0;
		s.total     = byte_count;
		s.kept      = '0;
		if (text_status == uvtw_pkg::ST_VALID) begin
			lim = (limit_reg > RING_SIZE) ? 7'(RING_SIZE) : limit_reg;
			if (lim == 0) begin
				s.keep_from = byte_count;
			end else if (char_total > lim) begin
				s.keep_from = {1'b0, start_offs[(char_total - lim) % RING_SIZE]};
				s.kept      = lim;
			end else begin
				s.kept = char_total[6:0];
			end
		end
		summaries_due = {summaries_due, s};
		cont_left   = '0;
		scalar      = '0;
		seq_class   = uvtw_pkg::CLS_NONE;
		text_status = uvtw_pkg::ST_VALID;
		byte_count  = '0;
		char_total  = '0;
	endtask

	// Sample both channels and the config port on the rising edge
	always @(posedge clk) begin : scoreboard
		summary_t want;
		if (arst_n) begin
			if (cfg_we) limit_reg = cfg_wdata;
			if (out_valid && !out_stall) begin
				if (summaries_due.size() == 0) begin
					$error("result word with no text ended");
					fails++;
				end else begin
					want = summaries_due.pop_front();
					if (status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, status);
						fails++;
					end
					if (keep_from !== want.keep_from) begin
						$error("keep_from: expected %0d, got %0d", want.keep_from, keep_from);
						fails++;
					end
					if (total_bytes !== want.total) begin
						$error("total_bytes: expected %0d, got %0d", want.total, total_bytes);
						fails++;
					end
					if (chars_kept !== want.kept) begin
						$error("chars_kept: expected %0d, got %0d", want.kept, chars_kept);
						fails++;
					end
				end
			end
			if (in_valid && !in_stall) begin
				accept_word('{data: data_byte, last: is_last, empty: is_empty});
				words_accepted++;
			end
		end
		word_taken <= arst_n && in_valid && !in_stall;
	end

	// Sender: hold the word while stalled, else offer the next one or idle
	always @(negedge clk) begin : sender
		word_t w;
		if (arst_n && (!in_valid || word_taken)) begin
			if (words_out.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
				w = words_out.pop_front();
				in_valid  <= 1'b1;
				data_byte <= w.data;
				is_last   <= w.last;
				is_empty  <= w.empty;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: random stalls, plus one long hold-off counted here
	always @(negedge clk) begin
		if (hold_left != 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (long_hold_req && !long_hold_done) begin
			out_stall      <= 1'b1;
			hold_left      <= LONG_HOLD;
			long_hold_done <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < rx_idle_pct);
		end
	end

	task automatic push_word(input logic [7:0] d, input logic l, input logic e);
		word_t w;
		w = '{data: d, last: l, empty: e};
		words_out = {words_out, w};
		words_queued++;
	endtask

	// Append one byte to the text being built
	task automatic add_byte(input logic [7:0] b);
		text_buf = {text_buf, b};
	endtask

	// Turn text_buf into words; either the final byte or an empty marker ends it
	task automatic send_text(input logic with_marker, input logic marker_last);
		int n;
		n = text_buf.size();
		for (int i = 0; i < n; i++)
			push_word(text_buf[i], !with_marker && i == n - 1, 1'b0);
		if (with_marker || n == 0) push_word(8'($urandom), marker_last, 1'b1);
		texts_queued++;
	endtask

	task automatic add_cont(input int n);
		repeat (n) add_byte(8'($urandom_range(8'hbf, 8'h80)));
	endtask

	// Append one well-formed character with random content
	task automatic add_good_char();
		logic [7:0] lead;
		case ($urandom_range(9))
			0, 1, 2, 3: add_byte(8'($urandom_range(8'h7f)));
			4, 5: begin
				add_byte(8'($urandom_range(8'hdf, 8'hc2)));
				add_cont(1);
			end
			6, 7: begin
				lead = 8'($urandom_range(8'hef, 8'he0));
				add_byte(lead);
				// keep clear of overlong forms and surrogates
				if (lead == 8'he0) add_byte(8'($urandom_range(8'hbf, 8'ha0)));
				else if (lead == 8'hed) add_byte(8'($urandom_range(8'h9f, 8'h80)));
				else add_cont(1);
				add_cont(1);
			end
			default: begin
				lead = 8'($urandom_range(8'hf4, 8'hf0));
				add_byte(lead);
				if (lead == 8'hf0) add_byte(8'($urandom_range(8'hbf, 8'h90)));
				else if (lead == 8'hf4) add_byte(8'($urandom_range(8'h8f, 8'h80)));
				else add_cont(1);
				add_cont(2);
			end
		endcase
	endtask

	// Append one broken character of a random kind
	task automatic add_bad_char();
		case ($urandom_range(7))
			0: begin   // overlong two-byte lead
				add_byte(8'($urandom_range(8'hc1, 8'hc0)));
				add_cont(1);
			end
			1: begin   // overlong three-byte form
				add_byte(8'he0);
				add_byte(8'($urandom_range(8'h9f, 8'h80)));
				add_cont(1);
			end
			2: begin   // overlong four-byte form
				add_byte(8'hf0);
				add_byte(8'($urandom_range(8'h8f, 8'h80)));
				add_cont(2);
			end
			3: begin   // surrogate
				add_byte(8'hed);
				add_byte(8'($urandom_range(8'hbf, 8'ha0)));
				add_cont(1);
			end
			4: begin   // beyond the last code point
				add_byte(8'hf4);
				add_byte(8'($urandom_range(8'hbf, 8'h90)));
				add_cont(2);
			end
			5: add_byte(8'($urandom_range(8'hff, 8'hf5)));
			6: add_cont(1);   // stray continuation
			default: begin    // lead followed by a non-continuation
				add_byte(8'($urandom_range(8'hdf, 8'hc2)));
				if ($urandom_range(1)) add_byte(8'($urandom_range(8'h7f)));
				else add_byte(8'($urandom_range(8'hff, 8'hc0)));
			end
		endcase
	endtask

	// Build and queue one text; noisy texts may carry errors or be cut short
	task automatic queue_text(input int n_chars, input logic noisy);
		int unsigned r;
		logic [7:0]  tail;
		text_buf.delete();
		repeat (n_chars) begin
			r = $urandom_range(99);
			if (noisy && r < 3) add_bad_char();
			else if (noisy && r < 5) add_byte(8'($urandom));
			else add_good_char();
		end
		if (noisy && $urandom_range(9) < 3 && text_buf.size() != 0) begin
			// drop the final continuation to leave a sequence open
			tail = text_buf[text_buf.size() - 1];
			if (tail[7:6] == 2'b10) void'(text_buf.pop_back());
		end
		send_text($urandom_range(9) == 0, 1'($urandom_range(1)));
	endtask

	// Wait until every word is in and every summary is back, then let the pipe settle
	task automatic drain();
		while (words_accepted != words_queued || summaries_due.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic set_limit(input logic [uvtw_pkg::LIMIT_W-1:0] v);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	// Queue random texts, mostly clean, until the word budget and a few texts are done
	task automatic run_random(input int unsigned budget);
		int unsigned first_word;
		int unsigned first_text;
		int unsigned r;
		int          n_chars;
		first_word = words_queued;
		first_text = texts_queued;
		while (words_queued - first_word < budget || texts_queued - first_text < 6) begin
			r = $urandom_range(99);
			if (r < 60) n_chars = $urandom_range(6);
			else if (r < 88) n_chars = $urandom_range(70, 7);
			else n_chars = $urandom_range(140, 71);
			queue_text(n_chars, $urandom_range(9) < 3);
		end
		drain();
	endtask

	initial begin
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;

		// Sender idles lightly, receiver heavily
		tx_idle_pct = 21;
		rx_idle_pct = 56;

		// Directed texts at the reset limit
		text_buf.delete();
		send_text(1'b1, 1'b0);                 // empty text, marker without is_last
		text_buf = {8'h41};
		send_text(1'b1, 1'b1);                 // one byte, then the marker ends it
		text_buf = {8'h00, 8'h7f, 8'hc2, 8'h80, 8'hdf, 8'hbf, 8'hef, 8'hbf, 8'hbf,
			8'hf4, 8'h8f, 8'hbf, 8'hbf};
		send_text(1'b0, 1'b0);                 // edges of each length class
		text_buf = {8'he0, 8'h80, 8'h41};
		send_text(1'b0, 1'b0);                 // overlong prefix, broken by a non-continuation byte
		text_buf = {8'hed, 8'ha0, 8'h80};
		send_text(1'b0, 1'b0);                 // surrogate
		text_buf = {8'he2};
		send_text(1'b0, 1'b0);                 // cut off at the end
		text_buf = {8'hf5};
		send_text(1'b0, 1'b0);                 // lead past the last code point
		drain();

		set_limit(7'd1);
		run_random(CHUNK_WORDS);
		set_limit(7'd0);
		run_random(CHUNK_WORDS);
		set_limit(7'd127);
		run_random(CHUNK_WORDS);

		// The sender has paused until every summary came back; now hold the
		// receiver off for a long stretch while short texts pour in, so the
		// block fills up and has to stall its input.
		tx_idle_pct = 0;
		long_hold_req <= 1'b1;
		repeat (40) queue_text($urandom_range(3, 1), 1'b0);
		drain();

		// Sender idles heavily, receiver lightly
		tx_idle_pct = 56;
		rx_idle_pct = 21;
		set_limit(7'd65);
		run_random(CHUNK_WORDS);
		set_limit(7'($urandom_range(63, 2)));
		run_random(CHUNK_WORDS);
		set_limit(7'd64);
		run_random(CHUNK_WORDS);

		// Neither side idles
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		set_limit(7'd63);
		run_random(CHUNK_WORDS);
		set_limit(7'($urandom_range(127)));
		run_random(CHUNK_WORDS);
		set_limit(7'd0);
		run_random(CHUNK_WORDS);

		if (fails == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

// ----- utf8_validate_tail_window_top.f -----
design/uvtw_pkg.sv
design/uvtw_ram.sv
design/utf8_validate_tail_window_top.sv
design/uvtw_checker.sv
bench/tb_top.sv
